// ===== rtl/core/bsfm_pkg.sv =====
package bsfm_pkg;

    // default sizes
    localparam int MAX_PATTERN_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    // fixed field widths
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 5;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int OFS_OUT_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic                 found;
        logic [OFS_OUT_W-1:0] match_offset;
    } t_out_item;

    // pattern byte k, bytes 16 and above read as zero
    function automatic logic [BYTE_W-1:0] pat_byte(
        input logic [CFG_W-1:0] lo,
        input logic [CFG_W-1:0] hi,
        input logic [LEN_W-1:0] k
    );
        logic [BYTE_W-1:0] b;
        if (k[LEN_W-1]) begin
            b = '0;
        end else if (k[3]) begin
            b = hi[{k[2:0], 3'b000} +: BYTE_W];
        end else begin
            b = lo[{k[2:0], 3'b000} +: BYTE_W];
        end
        return b;
    endfunction

endpackage

// ===== rtl/core/bsfm_window_cmp.sv =====
module bsfm_window_cmp
    import bsfm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic [MAX_PATTERN-1:0][BYTE_W-1:0] i_window,
    input  logic [CFG_W-1:0]                   i_pattern_low,
    input  logic [CFG_W-1:0]                   i_pattern_high,
    input  logic [LEN_W-1:0]                   i_len,
    output logic                               o_match
);

    localparam int POS_W = $clog2(MAX_PATTERN + 1) + 1;

    logic [MAX_PATTERN-1:0] lane_ok;

    // window slot j (newest at 0) lines up with pattern byte len-1-j
    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            lane_ok[j] = (POS_W'(j) >= POS_W'(i_len)) ||
                         (i_window[j] == pat_byte(i_pattern_low, i_pattern_high,
                                                  LEN_W'(i_len - LEN_W'(1) - LEN_W'(j))));
        end
    end

    assign o_match = &lane_ok;

endmodule

// ===== rtl/core/byte_sequence_first_match_unit.sv =====
// first-match byte pattern search: data bytes arrive one per transfer on the
// input channel, the last byte of a data set flagged by last_byte; the block
// compares the newest pattern_length bytes (up to MAX_PATTERN, pattern bytes
// beyond 16 read as zero) against the configured pattern in one parallel
// window compare and gives at most one result transfer per data set: found
// with the start offset of the first match, or not found on the last byte.
// an empty pattern matches at offset 0; after a match the rest of the set is
// dropped silently. the byte counter saturates at all ones, and the offset is
// cut to 32 bits. throughput is one byte per cycle unless a result waits on a
// stalled output; results pass the input register, the window compare, then
// the result register. a held result does not block bytes that give no result.
// configuration must be written only while idle; the block doesn't enforce it.
module byte_sequence_first_match_unit
    import bsfm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int MAXC_W = $clog2(MAX_PATTERN + 1) + LEN_W;

    // configuration registers
    logic [CFG_W-1:0] r_pattern_low;
    logic [CFG_W-1:0] r_pattern_high;
    logic [LEN_W-1:0] r_pattern_length;

    // input register
    logic     r_in_valid;
    t_in_item r_in;

    // search state
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] r_window;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] n_window;
    logic [OFFSET_BITS-1:0]             r_count;
    logic [OFFSET_BITS-1:0]             n_count;
    logic                               r_reported;

    // result register
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic [LEN_W-1:0]       len_c;
    logic                   window_match;
    logic                   hit;
    logic                   emit;
    logic                   out_free;
    logic                   advance;
    logic                   in_ready;
    logic [OFFSET_BITS-1:0] offset_full;

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_pattern_length <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATTERN_LOW:    r_pattern_low    <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pattern_high   <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // length clamped to the window depth
    assign len_c = (MAXC_W'(r_pattern_length) > MAXC_W'(MAX_PATTERN))
                 ? LEN_W'(MAX_PATTERN) : r_pattern_length;

    // window after shifting in the held byte, newest at slot 0
    always_comb begin
        n_window[0] = r_in.data_byte;
        for (int i = 1; i < MAX_PATTERN; i++) begin
            n_window[i] = r_window[i-1];
        end
    end

    // saturating byte count including the held byte
    assign n_count = (&r_count) ? r_count : r_count + OFFSET_BITS'(1);

    bsfm_window_cmp #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window_cmp (
        .i_window       (n_window),
        .i_pattern_low  (r_pattern_low),
        .i_pattern_high (r_pattern_high),
        .i_len          (len_c),
        .o_match        (window_match)
    );

    assign hit = (len_c == '0) ||
                 ((n_count >= OFFSET_BITS'(len_c)) && window_match);

    assign offset_full = (len_c == '0) ? '0 : n_count - OFFSET_BITS'(len_c);

    // a set already matched gives nothing more
    assign emit = !r_reported && (hit || r_in.last_byte);

    always_comb begin
        n_out.found        = hit;
        n_out.match_offset = hit ? OFS_OUT_W'(offset_full) : '0;
    end

    // handshake: the held byte moves on unless it has a result with nowhere to go
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!emit || out_free);
    assign in_ready   = !r_in_valid || advance;
    assign o_in_stall = !in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // search state; the window needs no clear as the count gates its use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_reported <= 1'b0;
        end else if (advance) begin
            if (r_in.last_byte) begin
                r_count    <= '0;
                r_reported <= 1'b0;
            end else if (!r_reported) begin
                r_count    <= n_count;
                r_reported <= hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && !r_reported) begin
            r_window <= n_window;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // not-found results carry a zero offset
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.found) |-> (o_out_item.match_offset == '0))
        else $error("not-found result with nonzero offset");

    // a matched set gives no second result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_reported) |-> !emit)
        else $error("result after a match in the same set");

    // the input side stalls only behind a held byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && emit && r_out_valid))
        else $error("input stalled without a pending result");

    // the last byte of a set leaves clean search state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.last_byte) |=> (r_count == '0 && !r_reported))
        else $error("search state not cleared at end of set");

endmodule

// ===== tb/tb_byte_sequence_first_match_unit.sv =====
module tb_byte_sequence_first_match_unit;
    import bsfm_pkg::*;

    // write index that maps to no register, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int SETTLE_CYCLES  = 8;     // margin for the pipeline to empty
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer or register write
    localparam int RANDOM_BYTES   = 400;

    logic            i_clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    t_in_item        in_item = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    t_out_item       out_item;
    logic            cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    byte_sequence_first_match_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // search predictor: own copy of the pattern registers and of the
    // per-set state (byte window, newest byte at index 0, and counter)
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  pat_lo = '0;
    logic [CFG_W-1:0]  pat_hi = '0;
    logic [LEN_W-1:0]  pat_len = '0;
    logic [BYTE_W-1:0] recent [16];
    logic [31:0]       bytes_seen = '0;
    bit                set_matched = 1'b0;

    t_out_item  match_reports [$];   // expected result transfers, oldest first
    t_in_item   pending_bytes [$];   // bytes waiting for the driver
    logic [7:0] set_buf [$];         // data set under construction
    int unsigned queued_bytes = 0;
    int unsigned mismatches = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // symbols used for noise and pattern in small-alphabet phases
    bit         alpha_mode = 1'b0;
    logic [7:0] sym0 = '0;
    logic [7:0] sym1 = '0;

    function automatic void clear_set();
        foreach (recent[k]) recent[k] = '0;
        bytes_seen  = '0;
        set_matched = 1'b0;
    endfunction

    // one accepted byte; returns 1 when a result transfer must follow
    function automatic bit scan_byte(input t_in_item it, output t_out_item res);
        int unsigned len;
        bit          hit;
        logic [127:0] pat_all;
        len     = (pat_len > 5'd16) ? 16 : int'(pat_len);
        pat_all = {pat_hi, pat_lo};
        res     = '0;
        hit     = 1'b0;
        // rest of a set after its match is dropped
        if (set_matched) begin
            if (it.last_byte) clear_set();
            return 1'b0;
        end
        for (int k = 15; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = it.data_byte;
        if (bytes_seen != '1) bytes_seen = bytes_seen + 1;
        if (len == 0) begin
            // empty pattern hits on the first byte of a set
            hit = 1'b1;
        end else if (bytes_seen >= len) begin
            hit = 1'b1;
            for (int k = 0; k < len; k++) begin
                if (recent[len-1-k] != pat_all[8*k +: 8]) hit = 1'b0;
            end
            res.match_offset = bytes_seen - len;
        end
        if (hit) begin
            res.found = 1'b1;
            if (it.last_byte) clear_set();
            else set_matched = 1'b1;
            return 1'b1;
        end
        if (it.last_byte) begin
            // end of set with no match: not-found report, offset zero
            res = '0;
            clear_set();
            return 1'b1;
        end
        res = '0;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // driver: takes bytes from the pending queue, random gaps between them
    // ------------------------------------------------------------------
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin
        t_out_item res;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            // byte transfer at this edge: work out what it should cause
            if (in_valid && !in_stall) begin
                if (scan_byte(in_item, res)) match_reports = {match_reports, res};
            end
            // the slot is free when nothing is held or the held byte just left
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_bytes.size() != 0 && send_idle_pct != 0
                             && $urandom_range(99) < send_idle_pct) begin
                    gap_left = $urandom_range(11);
                    in_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    in_item  <= pending_bytes.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall bursts on the output
    // ------------------------------------------------------------------
    int unsigned hold_left = 0;

    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
            hold_left = $urandom_range(11);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: sampled mid-cycle, where valid and stall are settled; a
    // transfer seen here completes at the next rising edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_out_item want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (match_reports.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result transfer: found=%0d offset=%0d",
                             out_item.found, out_item.match_offset);
                mismatches++;
            end else begin
                want = match_reports.pop_front();
                if (out_item.found !== want.found
                    || out_item.match_offset !== want.match_offset) begin
                    if (mismatches < 10)
                        $display({"mismatch: expected found=%0d offset=%0d, ",
                                  "got found=%0d offset=%0d"},
                                 want.found, want.match_offset,
                                 out_item.found, out_item.match_offset);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transfer or register write
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall) || cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] noise_byte();
        if (alpha_mode) return $urandom_range(1) ? sym1 : sym0;
        return 8'($urandom);
    endfunction

    // move the set under construction to the driver, last_byte on its end when close is set
    function automatic void flush_set(input bit close);
        t_in_item it;
        foreach (set_buf[k]) begin
            it.data_byte = set_buf[k];
            it.last_byte = close && (k == set_buf.size() - 1);
            pending_bytes = {pending_bytes, it};
        end
        queued_bytes += set_buf.size();
        set_buf.delete();
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_PATTERN_LOW:    pat_lo = val;
            CFG_PATTERN_HIGH:   pat_hi = val;
            CFG_PATTERN_LENGTH: pat_len = val[LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_pattern(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                                input logic [CFG_W-1:0] len_word);
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_PATTERN_LENGTH, len_word);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every byte has gone and every expected result has come,
    // then let the pipeline empty of bytes that cause no result
    task automatic drain();
        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || in_valid || match_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [7:0]       pat [16];
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        logic [CFG_W-1:0] len_word;
        logic [LEN_W-1:0] len;
        int unsigned      eff;
        int unsigned      kind;
        int unsigned      cut;
        int unsigned      flip_at;
        int unsigned      n_sets;

        clear_set();
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // empty pattern out of reset: hit on first byte, rest of set dropped
        set_buf = {set_buf, 8'h00};
        set_buf = {set_buf, 8'hFF};
        flush_set(1'b1);
        set_buf = {set_buf, 8'hA5};
        flush_set(1'b1);
        drain();

        // three-byte pattern 01 80 ff: match ending on last byte, match at
        // offset one, and a set shorter than the pattern
        load_pattern(64'hFFFF_FFFF_FFFF_8001, '0, 64'd3);
        @(negedge i_clk);
        set_buf = {set_buf, 8'h01};
        set_buf = {set_buf, 8'h80};
        set_buf = {set_buf, 8'hFF};
        flush_set(1'b1);
        set_buf = {set_buf, 8'h00};
        set_buf = {set_buf, 8'h01};
        set_buf = {set_buf, 8'h80};
        set_buf = {set_buf, 8'hFF};
        flush_set(1'b1);
        set_buf = {set_buf, 8'h01};
        set_buf = {set_buf, 8'h80};
        flush_set(1'b1);
        drain();

        // length 31 clips to a full 16-byte compare; junk above the length bits
        len_word = {$urandom, $urandom};
        len_word[LEN_W-1:0] = 5'd31;
        load_pattern('1, '0, len_word);
        @(negedge i_clk);
        repeat (8) set_buf = {set_buf, 8'hFF};
        repeat (8) set_buf = {set_buf, 8'h00};
        flush_set(1'b1);
        drain();

        // spare index: no register behind it
        write_reg(CFG_SPARE_INDEX, {$urandom, $urandom});
        @(posedge i_clk);
        cfg_we <= 1'b0;

        // random phases: new pattern, then a handful of data sets; a set may
        // be left open so that the next pattern lands in the middle of it
        while (queued_bytes < RANDOM_BYTES + 28) begin
            @(negedge i_clk);
            if (queued_bytes >= RANDOM_BYTES - 60) begin
                // last part of the run at full rate
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                case ($urandom_range(2))
                    0: send_idle_pct = 0;
                    1: send_idle_pct = 10;
                    default: send_idle_pct = 35;
                endcase
                case ($urandom_range(2))
                    0: recv_idle_pct = 0;
                    1: recv_idle_pct = 10;
                    default: recv_idle_pct = 35;
                endcase
            end
            alpha_mode = $urandom_range(1);
            sym0 = 8'($urandom);
            sym1 = 8'($urandom);
            for (int k = 0; k < 16; k++) begin
                pat[k] = alpha_mode ? ($urandom_range(1) ? sym1 : sym0) : 8'($urandom);
                if (k < 8) lo[8*k +: 8] = pat[k];
                else hi[8*(k-8) +: 8] = pat[k];
            end
            case ($urandom_range(19))
                0: len = 5'd0;
                1: len = 5'd16;
                2: len = 5'($urandom_range(17, 31));
                3: len = 5'($urandom_range(9, 15));
                default: len = 5'($urandom_range(1, 8));
            endcase
            len_word = {$urandom, $urandom};
            len_word[LEN_W-1:0] = len;
            if ($urandom_range(3) != 0) len_word[CFG_W-1:LEN_W] = '0;
            load_pattern(lo, hi, len_word);
            @(negedge i_clk);
            eff = (len > 5'd16) ? 16 : int'(len);

            n_sets = $urandom_range(2, 6);
            repeat (n_sets) begin
                kind = $urandom_range(9);
                repeat ($urandom_range(6)) set_buf = {set_buf, noise_byte()};
                if (kind <= 8) begin
                    // whole pattern, or a cut-short one
                    cut = (kind == 8 && eff > 1) ? $urandom_range(1, eff - 1) : eff;
                    for (int k = 0; k < cut; k++) set_buf = {set_buf, pat[k]};
                    // one byte of the pattern spoilt
                    if (kind == 7 && cut != 0) begin
                        flip_at = set_buf.size() - cut + $urandom_range(cut - 1);
                        set_buf[flip_at] = set_buf[flip_at] ^ 8'($urandom_range(1, 255));
                    end
                end
                repeat ($urandom_range(3)) set_buf = {set_buf, noise_byte()};
                if (set_buf.size() == 0) set_buf = {set_buf, noise_byte()};
                flush_set(1'b1);
            end
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 4)) set_buf = {set_buf, noise_byte()};
                flush_set(1'b0);
            end
            drain();
        end

        if (mismatches == 0 && match_reports.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
